>>> rtl/ssrl_pkg.sv
// Shared types, codes and constants of the sorted sparse-row list.
`default_nettype none
package ssrl_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam logic [30:0] SENTINEL_COL = 31'h7FFF_FFFF;

  // request codes
  localparam logic [2:0] REQ_START      = 3'd0;
  localparam logic [2:0] REQ_INSERT     = 3'd1;
  localparam logic [2:0] REQ_UPSERT     = 3'd2;
  localparam logic [2:0] REQ_NEXT_SMALL = 3'd3;
  localparam logic [2:0] REQ_NEXT_LOWER = 3'd4;
  localparam logic [2:0] REQ_REWIND     = 3'd5;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_NONE    = 2'd2;
  localparam logic [1:0] ST_UPDATED = 2'd3;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [30:0] row;
    logic [30:0] col;
    logic [15:0] level;
    logic [63:0] value_bits;
  } ssrl_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] out_col;
    logic [15:0] out_level;
    logic [63:0] out_value;
    logic [7:0]  live_entries;
  } ssrl_rsp_t;

  typedef struct packed {
    logic [30:0] col;
    logic [15:0] level;
    logic [63:0] value;
  } ssrl_entry_t;

  // cell operations
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_UPDATE,
    OP_CLEAR,
    OP_MOVE_ASC,
    OP_MOVE_LWR,
    OP_FLUSH
  } ssrl_op_e;

  // which cell drives the read chain
  typedef enum logic [1:0] {
    SEL_ASC,
    SEL_LWR,
    SEL_UPD
  } ssrl_sel_e;

  typedef struct packed {
    ssrl_op_e    op;
    ssrl_sel_e   sel;
    ssrl_entry_t ent;
  } ssrl_ctrl_t;

  // what a cell hands to its right neighbor
  typedef struct packed {
    logic        at;
    logic        asc;
    logic        lwr;
    ssrl_entry_t ent;
  } ssrl_link_t;

  // read chain token, moves one cell toward the head per cycle
  typedef struct packed {
    logic        hit;
    logic        miss;
    ssrl_entry_t ent;
  } ssrl_rd_t;

endpackage
`default_nettype wire

>>> rtl/ssrl_cell.sv
// One list position: entry storage, cursor marks and a read chain stage.
`default_nettype none
module ssrl_cell import ssrl_pkg::*; #(
  parameter int CW  = 8,
  parameter int IDX = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ssrl_ctrl_t    ctrl_i,
  input  wire logic [CW-1:0] count_i,
  input  wire ssrl_link_t    left_i,
  output ssrl_link_t         left_o,
  input  wire logic          match_right_i,
  output logic               match_o,
  input  wire ssrl_rd_t      rd_i,
  output ssrl_rd_t           rd_o
);

  logic        valid, is_tail, ge, at, match, last, sel;
  ssrl_entry_t ent_q;
  logic        asc_q, lwr_q;
  ssrl_rd_t    rd_q, rd_d;

  // position state
  assign valid   = CW'(IDX) <= count_i;
  assign is_tail = (CW+1)'(IDX) == ((CW+1)'(count_i) + (CW+1)'(1));
  assign ge      = valid && (ent_q.col >= ctrl_i.ent.col);
  assign at      = ge || !valid;
  assign match   = valid && (ent_q.col == ctrl_i.ent.col);
  // lowest slot of an equal run sits at its far end
  assign last    = match && !match_right_i;

  always_comb begin
    unique case (ctrl_i.sel)
      SEL_ASC: sel = left_i.asc && valid;
      SEL_LWR: sel = left_i.lwr && valid;
      SEL_UPD: sel = last;
      default: sel = 1'b0;
    endcase
  end

  // read chain: selected cell injects, first free slot injects a miss
  always_comb begin
    rd_d = rd_i;
    if (sel) begin
      rd_d.hit  = 1'b1;
      rd_d.miss = 1'b0;
      rd_d.ent  = ent_q;
    end else if (is_tail) begin
      rd_d.hit  = 1'b0;
      rd_d.miss = 1'b1;
      rd_d.ent  = ent_q;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_INSERT) begin
      if (at && !left_i.at) begin
        ent_q <= ctrl_i.ent;
      end else if (at) begin
        ent_q <= left_i.ent;
      end
    end else if (ctrl_i.op == OP_UPDATE) begin
      if (last && (ctrl_i.ent.level < ent_q.level)) begin
        ent_q.level <= ctrl_i.ent.level;
      end
    end
  end

  // cursor marks and read stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asc_q <= 1'b0;
      lwr_q <= 1'b0;
      rd_q  <= '0;
    end else begin
      unique case (ctrl_i.op)
        OP_CLEAR: begin
          asc_q <= 1'b0;
          lwr_q <= 1'b0;
        end
        OP_INSERT: begin
          if (at && !left_i.at) begin
            asc_q <= 1'b0;
            lwr_q <= 1'b0;
          end else if (at) begin
            asc_q <= left_i.asc;
            lwr_q <= left_i.lwr;
          end
        end
        OP_MOVE_ASC: asc_q <= sel;
        OP_MOVE_LWR: lwr_q <= sel;
        default: ;
      endcase
      if (ctrl_i.op == OP_FLUSH) begin
        rd_q <= '0;
      end else begin
        rd_q <= rd_d;
      end
    end
  end

  assign left_o  = '{at: at, asc: asc_q, lwr: lwr_q, ent: ent_q};
  assign match_o = match;
  assign rd_o    = rd_q;

endmodule
`default_nettype wire

>>> rtl/sorted_sparse_row_list.sv
// Top level: request sequencer over a chain of sorted list cells.
// Usage:
//   in channel (in_valid_i/in_ready_o, in_req_i) takes one request at a time;
//   out channel (out_valid_o/out_ready_i, out_rsp_o) returns one response each.
//   cfg channel writes base_row; always ready, write only while idle.
// Entries live in CAPACITY-1 cells in ascending column order; an insert shifts
// the tail of the chain one cell right, all cells moving together.
// Sequence, accept to response valid:
//   start row, insert, rewind, unused codes: a start state, then the response.
//   cursor step, insert-or-update: a start state, then a walk state until the
//   read token reaches the head from the chosen entry, or from the first free
//   cell on a miss (the chain end when full), moving one cell per cycle.
// A new request is taken only once the previous response has been taken, so
// the block holds at most one request at a time.
// A stalled receiver holds the response; nothing else changes meanwhile but base_row.
// Reset empties the list, parks both cursors on the head, clears base_row.
`default_nettype none
module sorted_sparse_row_list import ssrl_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire ssrl_req_t   in_req_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output ssrl_rsp_t        out_rsp_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [30:0] cfg_data_i
);

  localparam int CW = $clog2(CAPACITY);

  typedef enum logic [1:0] {S_IDLE, S_START, S_WALK, S_RESP} state_e;

  state_e        state_q;
  ssrl_req_t     req_q;
  logic [CW-1:0] count_q;
  logic          head_asc_q, head_lwr_q;
  logic [30:0]   row_q, base_q;
  logic [1:0]    st_q;
  ssrl_entry_t   oent_q;

  ssrl_ctrl_t    ctrl;
  ssrl_link_t    link  [CAPACITY];
  logic          match [1:CAPACITY];
  ssrl_rd_t      rd    [1:CAPACITY];
  logic          full, token, asc_ok, lwr_ok, walk_req;
  logic [31:0]   diag;

  assign full     = count_q == CW'(CAPACITY - 1);
  assign token    = rd[1].hit || rd[1].miss;
  assign diag     = {1'b0, row_q} + {1'b0, base_q};
  assign asc_ok   = rd[1].hit && (rd[1].ent.col != SENTINEL_COL);
  assign lwr_ok   = rd[1].hit && ({1'b0, rd[1].ent.col} < diag);
  assign walk_req = (req_q.req_type == REQ_UPSERT) || (req_q.req_type == REQ_NEXT_SMALL) ||
                    (req_q.req_type == REQ_NEXT_LOWER);

  // head sentinel and chain ends
  assign link[0]         = '{at: 1'b0, asc: head_asc_q, lwr: head_lwr_q, ent: '0};
  assign match[CAPACITY] = 1'b0;
  assign rd[CAPACITY]    = '{hit: 1'b0, miss: 1'b1, ent: '0};

  for (genvar k = 1; k < CAPACITY; k++) begin : g_cell
    ssrl_cell #(.CW(CW), .IDX(k)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .count_i       (count_q),
      .left_i        (link[k-1]),
      .left_o        (link[k]),
      .match_right_i (match[k+1]),
      .match_o       (match[k]),
      .rd_i          (rd[k+1]),
      .rd_o          (rd[k])
    );
  end

  // cell command
  always_comb begin
    ctrl.op  = OP_HOLD;
    ctrl.ent = '{col: req_q.col, level: req_q.level, value: req_q.value_bits};
    unique case (req_q.req_type)
      REQ_NEXT_SMALL: ctrl.sel = SEL_ASC;
      REQ_NEXT_LOWER: ctrl.sel = SEL_LWR;
      default:        ctrl.sel = SEL_UPD;
    endcase
    if (state_q == S_START) begin
      unique case (req_q.req_type)
        REQ_START, REQ_REWIND: ctrl.op = OP_CLEAR;
        REQ_INSERT:            ctrl.op = full ? OP_HOLD : OP_INSERT;
        REQ_UPSERT, REQ_NEXT_SMALL, REQ_NEXT_LOWER: ctrl.op = OP_FLUSH;
        default:               ctrl.op = OP_HOLD;
      endcase
    end else if (state_q == S_WALK && token) begin
      unique case (req_q.req_type)
        REQ_UPSERT:     ctrl.op = rd[1].hit ? OP_UPDATE : (full ? OP_HOLD : OP_INSERT);
        REQ_NEXT_SMALL: ctrl.op = asc_ok ? OP_MOVE_ASC : OP_HOLD;
        REQ_NEXT_LOWER: ctrl.op = lwr_ok ? OP_MOVE_LWR : OP_HOLD;
        default:        ctrl.op = OP_HOLD;
      endcase
    end
  end

  // sequencer, list state and response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      req_q      <= '0;
      count_q    <= '0;
      head_asc_q <= 1'b1;
      head_lwr_q <= 1'b1;
      row_q      <= '0;
      base_q     <= '0;
      st_q       <= ST_OK;
      oent_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        base_q <= cfg_data_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= in_req_i;
            state_q <= S_START;
          end
        end
        S_START: begin
          oent_q  <= '0;
          state_q <= walk_req ? S_WALK : S_RESP;
          if ((req_q.req_type == REQ_INSERT) && full) begin
            st_q <= ST_FULL;
          end else begin
            st_q <= ST_OK;
          end
          unique case (req_q.req_type)
            REQ_START: begin
              row_q      <= req_q.row;
              count_q    <= '0;
              head_asc_q <= 1'b1;
              head_lwr_q <= 1'b1;
            end
            REQ_REWIND: begin
              head_asc_q <= 1'b1;
              head_lwr_q <= 1'b1;
            end
            REQ_INSERT: begin
              if (!full) begin
                count_q <= count_q + CW'(1);
              end
            end
            default: ;
          endcase
        end
        S_WALK: begin
          if (token) begin
            state_q <= S_RESP;
            unique case (req_q.req_type)
              REQ_UPSERT: begin
                if (rd[1].hit) begin
                  st_q <= ST_UPDATED;
                end else if (full) begin
                  st_q <= ST_FULL;
                end else begin
                  count_q <= count_q + CW'(1);
                end
              end
              REQ_NEXT_SMALL: begin
                if (asc_ok) begin
                  head_asc_q <= 1'b0;
                  oent_q     <= rd[1].ent;
                end else begin
                  st_q <= ST_NONE;
                end
              end
              default: begin
                if (lwr_ok) begin
                  head_lwr_q <= 1'b0;
                  oent_q     <= rd[1].ent;
                end else begin
                  st_q <= ST_NONE;
                end
              end
            endcase
          end
        end
        S_RESP: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_RESP;
  assign cfg_ready_o = 1'b1;
  assign out_rsp_o   = '{status: st_q, out_col: oent_q.col, out_level: oent_q.level,
                         out_value: oent_q.value, live_entries: 8'(count_q)};

  // checks
  a_start_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_req_i.req_type == REQ_START)
      |=> ##1 (out_valid_o && out_rsp_o.live_entries == 8'd0))
    else $error("start row did not empty the list");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY - 1))
    else $error("entry count beyond capacity");
  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_rsp_o.status == ST_FULL) |-> full)
    else $error("full status with free cells");
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("request taken while response pending");

endmodule
`default_nettype wire

>>> tb/sorted_sparse_row_list_tb.sv
// Testbench for the sorted sparse-row list: directed and random requests checked against a behavioral list.
`timescale 1ns / 1ps
`default_nettype none
module sorted_sparse_row_list_tb;
  import ssrl_pkg::*;

  localparam int SLOTS = CAPACITY_DEF;
  localparam int STALL_LIMIT = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  ssrl_req_t   in_req_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  ssrl_rsp_t   out_rsp_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [30:0] cfg_data_i = '0;

  sorted_sparse_row_list DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_req_i(in_req_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_rsp_o(out_rsp_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // behavioral list state
  logic [30:0] lst_col [SLOTS];
  logic [15:0] lst_lvl [SLOTS];
  logic [63:0] lst_val [SLOTS];
  int          lst_nxt [SLOTS];
  int          used_slots, asc_pos, lwr_pos;
  logic [30:0] row_now, base_now;

  ssrl_req_t pending_reqs[$];
  ssrl_rsp_t expected_rsps[$];
  int        mismatches = 0;
  int        sent = 0, got = 0, idle_cycles = 0;
  bit        calm = 1'b0;   // no random idling while set
  bit        hold_off = 1'b0;

  function automatic logic [1:0] list_insert(ssrl_req_t r);
    int ct, pv, nx, n;
    if (used_slots >= SLOTS) return ST_FULL;
    ct = used_slots;
    used_slots++;
    lst_col[ct] = r.col;
    lst_lvl[ct] = r.level;
    lst_val[ct] = r.value_bits;
    pv = 0;
    nx = lst_nxt[0];
    n = 0;
    while (nx != 0 && r.col > lst_col[nx] && n < SLOTS) begin
      pv = nx;
      nx = lst_nxt[nx];
      n++;
    end
    lst_nxt[pv] = ct;
    lst_nxt[ct] = nx;
    return ST_OK;
  endfunction

  // compute the response for one request and advance the list
  function automatic ssrl_rsp_t list_step(ssrl_req_t r);
    ssrl_rsp_t p;
    int hit, nx;
    p = '0;
    case (r.req_type)
      REQ_START: begin
        row_now = r.row;
        used_slots = 1;
        asc_pos = 0;
        lwr_pos = 0;
        lst_nxt[0] = 0;
      end
      REQ_INSERT: p.status = list_insert(r);
      REQ_UPSERT: begin
        hit = -1;
        for (int i = 1; i < used_slots; i++)
          if (hit < 0 && lst_col[i] == r.col) hit = i;
        if (hit < 0) begin
          p.status = list_insert(r);
        end else begin
          if (r.level < lst_lvl[hit]) lst_lvl[hit] = r.level;
          p.status = ST_UPDATED;
        end
      end
      REQ_NEXT_SMALL: begin
        nx = lst_nxt[asc_pos];
        if (nx != 0 && lst_col[nx] != SENTINEL_COL) begin
          asc_pos = nx;
          p.out_col = lst_col[nx];
          p.out_level = lst_lvl[nx];
          p.out_value = lst_val[nx];
        end else p.status = ST_NONE;
      end
      REQ_NEXT_LOWER: begin
        nx = lst_nxt[lwr_pos];
        if (nx != 0 && {1'b0, lst_col[nx]} < {1'b0, row_now} + {1'b0, base_now}) begin
          lwr_pos = nx;
          p.out_col = lst_col[nx];
          p.out_level = lst_lvl[nx];
          p.out_value = lst_val[nx];
        end else p.status = ST_NONE;
      end
      REQ_REWIND: begin
        asc_pos = 0;
        lwr_pos = 0;
      end
      default: ;
    endcase
    p.live_entries = 8'(used_slots - 1);
    return p;
  endfunction

  function automatic ssrl_req_t make_req(logic [2:0] t, logic [30:0] rw, logic [30:0] c);
    ssrl_req_t r;
    r.req_type = t;
    r.row = rw;
    r.col = c;
    r.level = 16'($urandom);
    r.value_bits = {$urandom, $urandom};
    return r;
  endfunction

  function automatic logic [30:0] rand_col();
    case ($urandom_range(0, 5))
      0: return 31'($urandom_range(0, 15));
      1: return SENTINEL_COL;
      2: return SENTINEL_COL - 31'($urandom_range(1, 4));
      default: return 31'($urandom);
    endcase
  endfunction

  // accept bookkeeping at rising edges, next drive at falling edges
  bit req_taken = 1'b0;
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      expected_rsps.push_back(list_step(in_req_i));
      sent++;
      req_taken <= 1'b1;
    end else begin
      req_taken <= 1'b0;
    end
  end

  // driver: presents queued requests at falling edges
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || req_taken) begin
        if (pending_reqs.size() > 0 && !hold_off && (calm || $urandom_range(0, 99) >= 22)) begin
          in_req_i <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= calm || $urandom_range(0, 99) >= 22;
    end
  end

  // monitor and watchdog
  always @(posedge clk_i) begin
    ssrl_rsp_t e;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (out_valid_o && out_ready_i) begin
        got++;
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", out_rsp_o);
        end else begin
          e = expected_rsps.pop_front();
          if (out_rsp_o.status !== e.status || out_rsp_o.out_col !== e.out_col ||
              out_rsp_o.out_level !== e.out_level || out_rsp_o.out_value !== e.out_value ||
              out_rsp_o.live_entries !== e.live_entries) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", e, out_rsp_o);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request or response for %0d cycles", STALL_LIMIT);
      $display("[sorted_sparse_row_list] ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid_i || expected_rsps.size() > 0)
      @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
  endtask

  task automatic write_base(logic [30:0] b);
    @(negedge clk_i);
    cfg_data_i <= b;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    base_now = b;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // one phase of random traffic: mostly well-formed row builds and walks
  task automatic random_rows(int n);
    int k;
    logic [30:0] rw;
    k = 0;
    while (k < n) begin
      rw = ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 64));
      pending_reqs.push_back(make_req(REQ_START, rw, 31'($urandom)));
      k++;
      repeat ($urandom_range(1, 12)) begin
        logic [30:0] c;
        c = ($urandom_range(0, 2) == 0) ? rand_col() : 31'($urandom_range(0, 80));
        pending_reqs.push_back(make_req($urandom_range(0, 1) ? REQ_INSERT : REQ_UPSERT,
                                        31'($urandom), c));
        k++;
      end
      repeat ($urandom_range(1, 14)) begin
        logic [2:0] t;
        case ($urandom_range(0, 9))
          0: t = REQ_REWIND;
          1: t = 3'($urandom_range(6, 7));
          2: t = REQ_UPSERT;
          3, 4, 5: t = REQ_NEXT_SMALL;
          default: t = REQ_NEXT_LOWER;
        endcase
        pending_reqs.push_back(make_req(t, 31'($urandom), 31'($urandom_range(0, 80))));
        k++;
      end
    end
  endtask

  initial begin
    int mark;
    for (int i = 0; i < SLOTS; i++) begin
      lst_col[i] = '0; lst_lvl[i] = '0; lst_val[i] = '0; lst_nxt[i] = 0;
    end
    lst_col[0] = SENTINEL_COL;
    used_slots = 1; asc_pos = 0; lwr_pos = 0; row_now = '0; base_now = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, duplicates, update, sentinel column, unused codes
    write_base(31'd5);
    calm = 1'b1;
    pending_reqs.push_back(make_req(REQ_NEXT_SMALL, '0, '0));
    pending_reqs.push_back(make_req(REQ_START, 31'd10, '0));
    pending_reqs.push_back(make_req(REQ_INSERT, '0, 31'd12));
    pending_reqs.push_back(make_req(REQ_INSERT, '0, 31'd3));
    pending_reqs.push_back(make_req(REQ_INSERT, '0, 31'd12));
    pending_reqs.push_back(make_req(REQ_INSERT, '0, SENTINEL_COL));
    pending_reqs.push_back(make_req(REQ_INSERT, '0, '0));
    pending_reqs.push_back(make_req(REQ_UPSERT, '0, 31'd12));
    pending_reqs.push_back(make_req(REQ_UPSERT, '0, 31'd14));
    for (int i = 0; i < 7; i++) pending_reqs.push_back(make_req(REQ_NEXT_SMALL, '0, '0));
    for (int i = 0; i < 5; i++) pending_reqs.push_back(make_req(REQ_NEXT_LOWER, '0, '0));
    pending_reqs.push_back(make_req(3'd6, '1, '1));
    pending_reqs.push_back(make_req(3'd7, '0, '0));
    pending_reqs.push_back(make_req(REQ_REWIND, '0, '0));
    pending_reqs.push_back(make_req(REQ_NEXT_LOWER, '0, '0));
    drain();
    calm = 1'b0;

    // fill the store past capacity, then try four upserts and six lower-cursor steps
    write_base(31'h7FFF_FFFE);
    pending_reqs.push_back(make_req(REQ_START, 31'h7FFF_FFFE, '0));
    for (int i = 0; i < SLOTS + 1; i++)
      pending_reqs.push_back(make_req(REQ_INSERT, '0, rand_col()));
    for (int i = 0; i < 4; i++) pending_reqs.push_back(make_req(REQ_UPSERT, '0, rand_col()));
    for (int i = 0; i < 6; i++) pending_reqs.push_back(make_req(REQ_NEXT_LOWER, '0, '0));
    drain();

    // random phases across base_row settings, with a sender hold-off mid-way
    write_base(31'd0);
    mark = sent;
    random_rows(120);
    wait (sent >= mark + 60);
    hold_off = 1'b1;
    wait (!in_valid_i && expected_rsps.size() == 0);
    repeat (5) @(posedge clk_i);
    hold_off = 1'b0;
    drain();
    write_base(31'($urandom_range(0, 40)));
    calm = 1'b1;
    random_rows(100);
    drain();
    calm = 1'b0;
    write_base(31'($urandom));
    random_rows(120);
    drain();

    $display("covered %0d requests and %0d responses over five base_row settings,", sent, got);
    $display("including a full store, duplicate and sentinel columns, updates and cursor walks");
    if (mismatches == 0) $display("[sorted_sparse_row_list] OK");
    else $display("[sorted_sparse_row_list] ERROR");
    $finish;
  end
endmodule
`default_nettype wire
